### sv/i4p_pkg.sv
// i4p_pkg: shared types, mode codes and averaging helpers for the intra 4x4 luma predictor
`timescale 1ns / 1ps
`default_nettype none

package i4p_pkg;

  // stream word widths
  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 128;

  // substitute value for a missing neighbour pixel
  localparam logic [7:0] FILL_PIX = 8'h80;

  // prediction mode codes
  typedef enum logic [3:0] {
    MODE_VERT = 4'd0,
    MODE_HOR  = 4'd1,
    MODE_DC   = 4'd2,
    MODE_DDL  = 4'd3,
    MODE_DDR  = 4'd4,
    MODE_VR   = 4'd5,
    MODE_HD   = 4'd6,
    MODE_VL   = 4'd7,
    MODE_HU   = 4'd8
  } mode_t;

  // edge flag bit positions (set means the neighbouring macroblock is missing)
  localparam int unsigned EDGE_TOP = 0;
  localparam int unsigned EDGE_LEFT = 1;
  localparam int unsigned EDGE_TL = 2;
  localparam int unsigned EDGE_TR = 3;

  // one prediction request
  typedef struct packed {
    logic [3:0]      mode;
    logic [3:0]      block_index;
    logic [3:0]      edge_flags;
    logic [3:0][7:0] top_pixels;
    logic [3:0][7:0] top_right_pixels;
    logic [3:0][7:0] left_pixels;
    logic [7:0]      corner_pixel;
  } req_t;

  // neighbour availability
  typedef struct packed {
    logic up;
    logic left;
    logic ul;
    logic ur;
  } avail_t;

  // neighbours after substitution of missing ones
  typedef struct packed {
    avail_t          avail;
    logic [3:0][7:0] top;
    logic [3:0][7:0] topr;
    logic [3:0][7:0] left;
    logic [7:0]      corner;
  } nbr_t;

  // predicted block: row, then pixel (leftmost pixel in the low byte)
  typedef logic [3:0][3:0][7:0] pred_blk_t;

  // rounded average of two pixels
  function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

  // rounded 1-2-1 filter of three pixels
  function automatic logic [7:0] avg3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [9:0] s;
    s = {2'b0, a} + {1'b0, b, 1'b0} + {2'b0, c} + 10'd2;
    return s[9:2];
  endfunction

endpackage

`default_nettype wire

### sv/i4p_nbr.sv
// i4p_nbr: neighbour availability per block index and substitution of missing pixels
`timescale 1ns / 1ps
`default_nettype none

module i4p_nbr import i4p_pkg::*; (
  input  req_t req,
  output nbr_t nbr
);

  logic   top_ok;
  logic   left_ok;
  avail_t av;
  logic [3:0][7:0] tw;

  // availability from the block position inside the macroblock
  always_comb begin
    top_ok  = !req.edge_flags[EDGE_TOP];
    left_ok = !req.edge_flags[EDGE_LEFT];
    case (req.block_index)
      4'd0: begin
        av.up   = top_ok;
        av.left = left_ok;
        av.ul   = (top_ok || left_ok) && !req.edge_flags[EDGE_TL];
        av.ur   = top_ok;
      end
      4'd1, 4'd4: begin
        av.up   = top_ok;
        av.left = 1'b1;
        av.ul   = top_ok;
        av.ur   = top_ok;
      end
      4'd5: begin
        av.up   = top_ok;
        av.left = 1'b1;
        av.ul   = top_ok;
        av.ur   = top_ok && !req.edge_flags[EDGE_TR];
      end
      4'd2, 4'd8, 4'd10: begin
        av.up   = 1'b1;
        av.left = left_ok;
        av.ul   = left_ok;
        av.ur   = 1'b1;
      end
      4'd6, 4'd9, 4'd12, 4'd14: begin
        av.up   = 1'b1;
        av.left = 1'b1;
        av.ul   = 1'b1;
        av.ur   = 1'b1;
      end
      default: begin
        av.up   = 1'b1;
        av.left = 1'b1;
        av.ul   = 1'b1;
        av.ur   = 1'b0;
      end
    endcase
  end

  // substitute missing neighbours; up-right falls back to copies of pixel d
  always_comb begin
    tw         = av.up ? req.top_pixels : {4{FILL_PIX}};
    nbr.avail  = av;
    nbr.top    = tw;
    nbr.topr   = av.ur ? req.top_right_pixels : {4{tw[3]}};
    nbr.left   = av.left ? req.left_pixels : {4{FILL_PIX}};
    nbr.corner = av.ul ? req.corner_pixel : FILL_PIX;
  end

endmodule

`default_nettype wire

### sv/i4p_pred.sv
// i4p_pred: the nine intra 4x4 prediction modes over one set of neighbours
`timescale 1ns / 1ps
`default_nettype none

module i4p_pred import i4p_pkg::*; (
  input  req_t      req,
  input  nbr_t      nbr,
  output pred_blk_t blk
);

  logic [7:0]  tp  [0:8];   // a..h, h repeated
  logic [7:0]  ep  [0:8];   // l, k, j, i, x, a, b, c, d
  logic [7:0]  ddl [0:6];
  logic [7:0]  ddr [0:6];
  logic [7:0]  a, b, c, d, e, f, g, x, i, j, k, l;
  logic [9:0]  sum_t;
  logic [9:0]  sum_l;
  logic [10:0] sum_tl;
  logic [9:0]  sum_t_rnd;
  logic [9:0]  sum_l_rnd;
  logic [7:0]  dc;

  // neighbour pixels by name
  always_comb begin
    a = nbr.top[0];
    b = nbr.top[1];
    c = nbr.top[2];
    d = nbr.top[3];
    e = nbr.topr[0];
    f = nbr.topr[1];
    g = nbr.topr[2];
    x = nbr.corner;
    i = nbr.left[0];
    j = nbr.left[1];
    k = nbr.left[2];
    l = nbr.left[3];
  end

  // filtered diagonals for the diagonal down-left and down-right modes
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      tp[n]     = nbr.top[n];
      tp[n + 4] = nbr.topr[n];
      ep[n]     = nbr.left[3 - n];
      ep[n + 5] = nbr.top[n];
    end
    tp[8] = nbr.topr[3];
    ep[4] = nbr.corner;
    for (int n = 0; n < 7; n++) begin
      ddl[n] = avg3(tp[n], tp[n + 1], tp[n + 2]);
      ddr[n] = avg3(ep[n], ep[n + 1], ep[n + 2]);
    end
  end

  // dc value from the raw neighbours that are present
  always_comb begin
    sum_t = {2'b0, req.top_pixels[0]} + {2'b0, req.top_pixels[1]}
          + {2'b0, req.top_pixels[2]} + {2'b0, req.top_pixels[3]};
    sum_l = {2'b0, req.left_pixels[0]} + {2'b0, req.left_pixels[1]}
          + {2'b0, req.left_pixels[2]} + {2'b0, req.left_pixels[3]};
    sum_tl    = {1'b0, sum_t} + {1'b0, sum_l} + 11'd4;
    sum_t_rnd = sum_t + 10'd2;
    sum_l_rnd = sum_l + 10'd2;
    case ({nbr.avail.up, nbr.avail.left})
      2'b10:   dc = sum_t_rnd[9:2];
      2'b01:   dc = sum_l_rnd[9:2];
      2'b11:   dc = sum_tl[10:3];
      default: dc = FILL_PIX;
    endcase
  end

  // mode select
  always_comb begin
    blk = {16{FILL_PIX}};
    case (mode_t'(req.mode))
      MODE_VERT: begin
        for (int r = 0; r < 4; r++) blk[r] = req.top_pixels;
      end
      MODE_HOR: begin
        for (int r = 0; r < 4; r++) blk[r] = {4{req.left_pixels[r]}};
      end
      MODE_DC: begin
        blk = {16{dc}};
      end
      MODE_DDL: begin
        for (int r = 0; r < 4; r++) begin
          for (int p = 0; p < 4; p++) blk[r][p] = ddl[r + p];
        end
      end
      MODE_DDR: begin
        for (int r = 0; r < 4; r++) begin
          for (int p = 0; p < 4; p++) blk[r][p] = ddr[3 + p - r];
        end
      end
      MODE_VR: begin
        blk[0] = {avg2(c, d), avg2(b, c), avg2(a, b), avg2(x, a)};
        blk[1] = {avg3(b, c, d), avg3(a, b, c), avg3(x, a, b), avg3(i, x, a)};
        blk[2] = {avg2(b, c), avg2(a, b), avg2(x, a), avg3(j, i, x)};
        blk[3] = {avg3(a, b, c), avg3(x, a, b), avg3(i, x, a), avg3(i, j, k)};
      end
      MODE_HD: begin
        blk[0] = {avg3(a, b, c), avg3(x, a, b), avg3(i, x, a), avg2(x, i)};
        blk[1] = {avg3(i, x, a), avg2(x, i), avg3(j, i, x), avg2(j, i)};
        blk[2] = {avg3(j, i, x), avg2(j, i), avg3(k, j, i), avg2(k, j)};
        blk[3] = {avg3(k, j, i), avg2(k, j), avg3(l, k, j), avg2(l, k)};
      end
      MODE_VL: begin
        blk[0] = {avg2(d, e), avg2(c, d), avg2(b, c), avg2(a, b)};
        blk[1] = {avg3(d, e, f), avg3(c, d, e), avg3(b, c, d), avg3(a, b, c)};
        blk[2] = {avg2(e, f), avg2(d, e), avg2(c, d), avg2(b, c)};
        blk[3] = {avg3(e, f, g), avg3(d, e, f), avg3(c, d, e), avg3(b, c, d)};
      end
      MODE_HU: begin
        blk[0] = {avg3(j, k, l), avg2(j, k), avg3(i, j, k), avg2(i, j)};
        blk[1] = {avg3(k, l, l), avg2(k, l), avg3(j, k, l), avg2(j, k)};
        blk[2] = {l, l, avg3(k, l, l), avg2(k, l)};
        blk[3] = {4{l}};
      end
      default: begin
        blk = {16{FILL_PIX}};
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/intra4x4_luma_predictor_unit.sv
// intra4x4_luma_predictor_unit: top level, input register, prediction logic, output register
//
//  channel | dir | ports                          | word
//  --------+-----+--------------------------------+------------------------------------------
//  in      | in  | in_tvalid, in_tready, in_tdata | one request (mode, index, flags, pixels)
//  out     | out | out_tvalid, out_tready, out_tdata | one predicted 4x4 block, 4 rows
//
//  an accepted request passes the input register, then the availability and mode logic
//  feeding the output register; one word per cycle sustained while out_tready is high;
//  both registers advance whenever the stage after them is empty or being drained, so a
//  held output still lets one more word in
//  rst_n clears both valid flags; data registers are not reset
//  in_tready depends on out_tready through the stage-ready chain
`timescale 1ns / 1ps
`default_nettype none

module intra4x4_luma_predictor_unit import i4p_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [3:0] mode, [7:4] block_index, [11:8] edge_flags, [43:12] top_pixels,
  // [75:44] top_right_pixels, [107:76] left_pixels, [115:108] corner_pixel, [119:116] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [31:0] pred_row0, [63:32] pred_row1, [95:64] pred_row2, [127:96] pred_row3
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  req_t      in_req;
  logic      s1_vld_r, s1_vld_nxt;
  req_t      s1_req_r, s1_req_nxt;
  logic      out_vld_r, out_vld_nxt;
  pred_blk_t out_blk_r, out_blk_nxt;
  logic      out_free;
  nbr_t      nbr;
  pred_blk_t blk;

  // unpack the input word
  always_comb begin
    in_req.mode             = in_tdata[3:0];
    in_req.block_index      = in_tdata[7:4];
    in_req.edge_flags       = in_tdata[11:8];
    in_req.top_pixels       = in_tdata[43:12];
    in_req.top_right_pixels = in_tdata[75:44];
    in_req.left_pixels      = in_tdata[107:76];
    in_req.corner_pixel     = in_tdata[115:108];
  end

  // stage ready chain
  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || out_free;

  // input register
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    s1_req_nxt = s1_req_r;
    if (in_tready) begin
      s1_vld_nxt = in_tvalid;
      s1_req_nxt = in_req;
    end
  end

  i4p_nbr u_nbr (
    .req (s1_req_r),
    .nbr (nbr)
  );

  i4p_pred u_pred (
    .req (s1_req_r),
    .nbr (nbr),
    .blk (blk)
  );

  // output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    out_blk_nxt = out_blk_r;
    if (out_free) begin
      out_vld_nxt = s1_vld_r;
      out_blk_nxt = blk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r  <= s1_req_nxt;
    out_blk_r <= out_blk_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_blk_r;

endmodule

`default_nettype wire

### sv/i4p_chk.sv
// i4p_chk: port-level checks for the intra 4x4 luma predictor, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module i4p_chk import i4p_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // reset leaves no word on the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // a free output stage always lets a word in
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while output stage is free");

  // an output word appears from an empty output only after an accept, through the input and output registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("output word without a matching input word");

endmodule

bind intra4x4_luma_predictor_unit i4p_chk u_i4p_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### tb/tb_intra4x4_luma_predictor_unit.sv
// tb_intra4x4_luma_predictor_unit: self-checking stream testbench for the intra 4x4 luma predictor
`timescale 1ns / 1ps

module tb_intra4x4_luma_predictor_unit;
  import i4p_pkg::*;

  // mode codes outside the nine defined ones
  localparam logic [3:0] MODE_UNUSED_LO = 4'd9;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

  // edge flag patterns (set means the neighbouring macroblock is missing)
  localparam logic [3:0] EF_NONE = 4'd0;
  localparam logic [3:0] EF_TOP  = 4'(1 << EDGE_TOP);
  localparam logic [3:0] EF_LEFT = 4'(1 << EDGE_LEFT);
  localparam logic [3:0] EF_TL   = 4'(1 << EDGE_TL);
  localparam logic [3:0] EF_TR   = 4'(1 << EDGE_TR);
  localparam logic [3:0] EF_ALL  = EF_TOP | EF_LEFT | EF_TL | EF_TR;

  localparam logic [31:0] FILL_ROW = {4{FILL_PIX}};
  localparam int RANDOM_REQS = 500;
  localparam int TAIL_CYCLES = 12;

  // one prediction request as driven on the input stream
  typedef struct {
    logic [3:0]  mode;
    logic [3:0]  blk;
    logic [3:0]  edges;
    logic [31:0] top;
    logic [31:0] topr;
    logic [31:0] left;
    logic [7:0]  corner;
    bit          drain;   // hold this word back until all blocks are out
  } pred_req_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  pred_req_t      req_q[$];
  logic [127:0]   pred_blk_q[$];
  pred_req_t      cur_req;
  bit             in_took;
  int             n_acc;
  int             n_chk;
  int             err_cnt;
  int             mode_seen[16];
  bit             calm;

  intra4x4_luma_predictor_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // rounded mean of two pixels
  function automatic int mean2(int p, int q);
    return (p + q + 1) >> 1;
  endfunction

  // rounded 1-2-1 filter of three pixels
  function automatic int mean3(int p, int q, int r);
    return (p + 2 * q + r + 2) >> 2;
  endfunction

  // four pixels into one row, leftmost in the low byte
  function automatic logic [31:0] pix4(int p0, int p1, int p2, int p3);
    return {8'(p3), 8'(p2), 8'(p1), 8'(p0)};
  endfunction

  // expected 4x4 block for one request: rows 0..3 from the low word up
  function automatic logic [127:0] predict_block(pred_req_t rq);
    bit          up, lf, ul, ur, top_ok, left_ok;
    logic [31:0] tw, rw, lw;
    logic [31:0] rows [4];
    int          A, B, C, D, E, F, G, H, I, J, K, L, X;
    int          z [7];
    int          w [7];
    int          st, sl, dc, q;
    int          y;
    top_ok  = !rq.edges[EDGE_TOP];
    left_ok = !rq.edges[EDGE_LEFT];
    // neighbour availability from the position inside the macroblock
    case (rq.blk)
      4'd0: begin
        up = top_ok; lf = left_ok; ur = top_ok;
        ul = (top_ok || left_ok) && !rq.edges[EDGE_TL];
      end
      4'd1, 4'd4: begin
        up = top_ok; ul = top_ok; ur = top_ok; lf = 1'b1;
      end
      4'd5: begin
        up = top_ok; ul = top_ok; lf = 1'b1;
        ur = top_ok && !rq.edges[EDGE_TR];
      end
      4'd2, 4'd8, 4'd10: begin
        lf = left_ok; ul = left_ok; up = 1'b1; ur = 1'b1;
      end
      4'd6, 4'd9, 4'd12, 4'd14: begin
        up = 1'b1; lf = 1'b1; ul = 1'b1; ur = 1'b1;
      end
      default: begin
        up = 1'b1; lf = 1'b1; ul = 1'b1; ur = 1'b0;
      end
    endcase
    // substitute missing neighbours; missing up-right repeats pixel D
    tw = up ? rq.top : FILL_ROW;
    rw = ur ? rq.topr : {4{tw[31:24]}};
    lw = lf ? rq.left : FILL_ROW;
    X  = ul ? rq.corner : FILL_PIX;
    A = tw[7:0];  B = tw[15:8];  C = tw[23:16]; D = tw[31:24];
    E = rw[7:0];  F = rw[15:8];  G = rw[23:16]; H = rw[31:24];
    I = lw[7:0];  J = lw[15:8];  K = lw[23:16]; L = lw[31:24];
    for (y = 0; y < 4; y++) rows[y] = FILL_ROW;
    case (rq.mode)
      MODE_VERT: for (y = 0; y < 4; y++) rows[y] = rq.top;
      MODE_HOR:  for (y = 0; y < 4; y++) rows[y] = {4{rq.left[8*y +: 8]}};
      MODE_DC: begin
        st = 0;
        sl = 0;
        for (y = 0; y < 4; y++) begin
          st += rq.top[8*y +: 8];
          sl += rq.left[8*y +: 8];
        end
        if (up && lf) dc = (st + sl + 4) >> 3;
        else if (up) dc = (st + 2) >> 2;
        else if (lf) dc = (sl + 2) >> 2;
        else dc = FILL_PIX;
        for (y = 0; y < 4; y++) rows[y] = {4{8'(dc)}};
      end
      MODE_DDL: begin
        z[0] = mean3(A, B, C); z[1] = mean3(B, C, D); z[2] = mean3(C, D, E);
        z[3] = mean3(D, E, F); z[4] = mean3(E, F, G); z[5] = mean3(F, G, H);
        z[6] = (G + 3 * H + 2) >> 2;
        for (y = 0; y < 4; y++) rows[y] = pix4(z[y], z[y+1], z[y+2], z[y+3]);
      end
      MODE_DDR: begin
        w[0] = mean3(L, K, J); w[1] = mean3(K, J, I); w[2] = mean3(J, I, X);
        w[3] = mean3(I, X, A); w[4] = mean3(X, A, B); w[5] = mean3(A, B, C);
        w[6] = mean3(B, C, D);
        for (y = 0; y < 4; y++) rows[y] = pix4(w[3-y], w[4-y], w[5-y], w[6-y]);
      end
      MODE_VR: begin
        rows[0] = pix4(mean2(X, A), mean2(A, B), mean2(B, C), mean2(C, D));
        rows[1] = pix4(mean3(I, X, A), mean3(X, A, B), mean3(A, B, C), mean3(B, C, D));
        rows[2] = pix4(mean3(J, I, X), mean2(X, A), mean2(A, B), mean2(B, C));
        rows[3] = pix4(mean3(I, J, K), mean3(I, X, A), mean3(X, A, B), mean3(A, B, C));
      end
      MODE_HD: begin
        rows[0] = pix4(mean2(X, I), mean3(I, X, A), mean3(X, A, B), mean3(A, B, C));
        rows[1] = pix4(mean2(J, I), mean3(J, I, X), mean2(X, I), mean3(I, X, A));
        rows[2] = pix4(mean2(K, J), mean3(K, J, I), mean2(J, I), mean3(J, I, X));
        rows[3] = pix4(mean2(L, K), mean3(L, K, J), mean2(K, J), mean3(K, J, I));
      end
      MODE_VL: begin
        rows[0] = pix4(mean2(A, B), mean2(B, C), mean2(C, D), mean2(D, E));
        rows[1] = pix4(mean3(A, B, C), mean3(B, C, D), mean3(C, D, E), mean3(D, E, F));
        rows[2] = pix4(mean2(B, C), mean2(C, D), mean2(D, E), mean2(E, F));
        rows[3] = pix4(mean3(B, C, D), mean3(C, D, E), mean3(D, E, F), mean3(E, F, G));
      end
      MODE_HU: begin
        q = (K + 3 * L + 2) >> 2;
        rows[0] = pix4(mean2(I, J), mean3(I, J, K), mean2(J, K), mean3(J, K, L));
        rows[1] = pix4(mean2(J, K), mean3(J, K, L), mean2(K, L), q);
        rows[2] = pix4(mean2(K, L), q, L, L);
        rows[3] = pix4(L, L, L, L);
      end
      default: ;
    endcase
    return {rows[3], rows[2], rows[1], rows[0]};
  endfunction

  // random pixel, biased toward the extremes
  function automatic logic [7:0] rand_pix();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] rand_row();
    return {rand_pix(), rand_pix(), rand_pix(), rand_pix()};
  endfunction

  task automatic add_req(input logic [3:0] m, input logic [3:0] b, input logic [3:0] e,
                         input logic [31:0] t, input logic [31:0] tr,
                         input logic [31:0] l, input logic [7:0] c, input bit drn);
    pred_req_t rq;
    rq.mode = m; rq.blk = b; rq.edges = e;
    rq.top = t; rq.topr = tr; rq.left = l; rq.corner = c;
    rq.drain = drn;
    req_q.push_back(rq);
  endtask

  // no idling on either side for a stretch in the middle of the random part
  assign calm = (n_acc >= 200) && (n_acc < 300);

  // input driver: present the next request once the current word is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (req_q.size() > 0 && !(req_q[0].drain && pred_blk_q.size() != 0) &&
          (calm || $urandom_range(0, 99) >= 33)) begin
        cur_req = req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {4'b0, cur_req.corner, cur_req.left, cur_req.topr, cur_req.top,
                      cur_req.edges, cur_req.blk, cur_req.mode};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 33);
  end

  // record accepted requests and check each delivered block
  always @(posedge clk) begin
    logic [127:0] exp_blk;
    int           r;
    in_took = rst_n && in_tvalid && in_tready;
    if (in_took) begin
      pred_blk_q.push_back(predict_block(cur_req));
      mode_seen[cur_req.mode]++;
      n_acc++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pred_blk_q.size() == 0) begin
        $error("block delivered with none outstanding: %h", out_tdata);
        err_cnt++;
      end else begin
        exp_blk = pred_blk_q.pop_front();
        n_chk++;
        for (r = 0; r < 4; r++) begin
          if (out_tdata[32*r +: 32] !== exp_blk[32*r +: 32]) begin
            $error("pred_row%0d mismatch: expected %h, actual %h",
                   r, exp_blk[32*r +: 32], out_tdata[32*r +: 32]);
            err_cnt++;
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int n, codes;
    logic [3:0] m;
    // directed: extremes, every mode, availability corner cases
    add_req(MODE_VERT, 4'd0, EF_NONE, '0, '0, '0, 8'h00, 1'b0);
    add_req(MODE_HOR, 4'd0, EF_ALL, '1, '1, '1, 8'hFF, 1'b0);
    add_req(MODE_DC, 4'd0, EF_TOP | EF_LEFT, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_DC, 4'd0, EF_TOP, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_DC, 4'd0, EF_LEFT, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_DC, 4'd6, EF_ALL, '1, '1, '1, 8'hFF, 1'b0);
    add_req(MODE_DDL, 4'd3, EF_NONE, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_DDL, 4'd5, EF_TR, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_DDL, 4'd5, EF_NONE, '1, '1, '1, 8'hFF, 1'b0);
    add_req(MODE_DDL, 4'd0, EF_TOP, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_DDR, 4'd0, EF_TL, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_DDR, 4'd0, EF_TOP, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_VR, 4'd2, EF_LEFT, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_VR, 4'd9, EF_NONE, '1, '1, '1, 8'hFF, 1'b0);
    add_req(MODE_HD, 4'd1, EF_TOP, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_HD, 4'd12, EF_NONE, '0, '0, '0, 8'h00, 1'b0);
    add_req(MODE_VL, 4'd13, EF_NONE, '1, '1, '1, 8'hFF, 1'b0);
    add_req(MODE_VL, 4'd4, EF_TOP, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_HU, 4'd4, EF_ALL, '1, '1, '1, 8'hFF, 1'b0);
    add_req(MODE_HU, 4'd15, EF_NONE, '0, '0, '0, 8'h00, 1'b0);
    add_req(MODE_VERT, 4'd1, EF_TOP, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_HOR, 4'd2, EF_LEFT, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_UNUSED_LO, 4'd7, EF_NONE, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    add_req(MODE_UNUSED_HI, 4'd15, EF_ALL, rand_row(), rand_row(), rand_row(), rand_pix(), 1'b0);
    // random: mostly defined modes, any index and edge pattern
    for (n = 0; n < RANDOM_REQS; n++) begin
      if ($urandom_range(0, 9) == 0) m = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      else m = 4'($urandom_range(MODE_VERT, MODE_HU));
      add_req(m, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              rand_row(), rand_row(), rand_row(), rand_pix(),
              (n == 0) || (n == RANDOM_REQS / 2));
    end

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // wait for every request to be taken and every block to come back
    while (req_q.size() != 0 || in_tvalid || pred_blk_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    codes = 0;
    for (n = 0; n < 16; n++) if (mode_seen[n] != 0) codes++;
    $display("covered %0d requests over %0d of 16 mode codes, all block indices and edge flags",
             n_acc, codes);
    $display("%0d predicted blocks compared, %0d mismatches", n_chk, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("timeout: %0d requests taken, %0d blocks outstanding", n_acc, pred_blk_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### intra4x4_luma_predictor_unit.f
sv/i4p_pkg.sv
sv/i4p_nbr.sv
sv/i4p_pred.sv
sv/intra4x4_luma_predictor_unit.sv
sv/i4p_chk.sv
tb/tb_intra4x4_luma_predictor_unit.sv
